>>> rtl/core/sba_pkg.sv
// Shared constants for the sprite batch assembler: command and record codes,
// register indexes and reset values. No dependencies.
package sba_pkg;

   localparam int MAX_SLOTS_DEFAULT          = 32;
   localparam int COLOUR_STACK_DEPTH_DEFAULT = 8;

   // Command codes
   localparam logic [2:0] CMD_BEGIN = 3'd0;
   localparam logic [2:0] CMD_DRAW  = 3'd1;
   localparam logic [2:0] CMD_END   = 3'd2;
   localparam logic [2:0] CMD_PUSH  = 3'd3;
   localparam logic [2:0] CMD_POP   = 3'd4;

   // Result record kinds
   localparam logic [1:0] KIND_VERTEX = 2'd0;
   localparam logic [1:0] KIND_BIND   = 2'd1;
   localparam logic [1:0] KIND_DRAW   = 2'd2;

   // Register indexes
   localparam logic CSR_MAX_QUADS  = 1'b0;
   localparam logic CSR_SLOT_LIMIT = 1'b1;

   localparam logic [15:0] MAX_QUADS_RESET  = 16'd20000;
   localparam logic [5:0]  SLOT_LIMIT_RESET = 6'd10;
   localparam logic [5:0]  SLOT_LIMIT_FLOOR = 6'd2;
   localparam logic [31:0] WHITE_COLOUR     = 32'hFFFF_FFFF;
   localparam logic [15:0] BLANK_TEXTURE    = 16'h0000;

endpackage

>>> rtl/core/sba_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sba_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/sprite_batch_assembler.sv
// Top level of the sprite batch assembler: command sequencer, slot search and
// vertex emission. Depends on sba_pkg and sba_ram.
//
// The block takes one command item at a time (start while busy is low) and
// emits its result items one per cycle on the rsp_ ports, each marked by
// rsp_valid for exactly one cycle; the receiver cannot stall the block, so it
// must take every result in the cycle it is shown. rsp_last marks the final
// result of a command. Begin, push, pop and ignored commands only pass
// through dispatch. A draw goes through dispatch, search preparation and the
// search, which reads slot table entries up to the hit (all slots_used on a
// miss), then emits four vertices; a miss adds the texture in between. The
// search reads the slot table RAM one entry per cycle through a single
// comparator. A flush (before a draw at the quad limit, on a miss with the
// slot table full, or at end of scene) emits one bind record per used slot
// and then the draw record if quads are pending, and nothing otherwise.
// Slot table and colour stack live in RAM; slot 0 (white) and the bottom
// colour (opaque white) are never written and read as their reset values,
// so no clearing pass runs after reset. Configuration (csr_) is accepted
// whenever busy is low.
module sprite_batch_assembler
   import sba_pkg::*;
#(
   parameter int MAX_SLOTS          = MAX_SLOTS_DEFAULT,
   parameter int COLOUR_STACK_DEPTH = COLOUR_STACK_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // command items
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_cmd,
   input  logic [15:0] req_texture_id,
   input  logic [31:0] req_loc_x,
   input  logic [31:0] req_loc_y,
   input  logic [31:0] req_loc_z,
   input  logic [15:0] req_size_w,
   input  logic [15:0] req_size_h,
   input  logic [15:0] req_pivot_x,
   input  logic [15:0] req_pivot_y,
   input  logic [63:0] req_uv_rect,
   input  logic [31:0] req_colour,
   // result items
   output logic        rsp_valid,
   output logic [1:0]  rsp_kind,
   output logic [31:0] rsp_pos_x,
   output logic [31:0] rsp_pos_y,
   output logic [31:0] rsp_pos_z,
   output logic [31:0] rsp_vert_colour,
   output logic [15:0] rsp_tex_u,
   output logic [15:0] rsp_tex_v,
   output logic [4:0]  rsp_slot,
   output logic [15:0] rsp_bound_texture,
   output logic [18:0] rsp_index_count,
   output logic        rsp_last,
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   // Slots above 32 cannot be named by the 5-bit slot field.
   localparam int SLOT_DEPTH = (MAX_SLOTS < 32) ? MAX_SLOTS : 32;
   localparam int SAW        = $clog2(SLOT_DEPTH);
   localparam int UW         = SAW + 1;
   localparam int CAW        = $clog2(COLOUR_STACK_DEPTH);
   localparam int DW         = CAW + 1;

   // Sequencer states
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_FL_PREP  = 4'd2;
   localparam logic [3:0] S_FL_BIND  = 4'd3;
   localparam logic [3:0] S_FL_DRAW  = 4'd4;
   localparam logic [3:0] S_SR_PREP  = 4'd5;
   localparam logic [3:0] S_SR       = 4'd6;
   localparam logic [3:0] S_MISS     = 4'd7;
   localparam logic [3:0] S_ADD      = 4'd8;
   localparam logic [3:0] S_VTX      = 4'd9;

   // Where to go once a flush finishes
   localparam logic [1:0] RET_IDLE   = 2'd0;
   localparam logic [1:0] RET_SEARCH = 2'd1;
   localparam logic [1:0] RET_ADD    = 2'd2;

   // Control state
   logic [3:0]     state_ff, state_in;
   logic [1:0]     ret_ff, ret_in;
   logic           active_ff, active_in;
   logic [UW-1:0]  used_ff, used_in;
   logic [15:0]    pending_ff, pending_in;
   logic [DW-1:0]  depth_ff, depth_in;
   logic [SAW-1:0] idx_ff, idx_in;
   logic [SAW-1:0] slot_ff, slot_in;
   logic [1:0]     vc_ff, vc_in;
   logic [15:0]    max_quads_ff, max_quads_in;
   logic [5:0]     slot_limit_ff, slot_limit_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_rd_zero_ff;

   // Captured command item
   logic [2:0]  cmd_ff;
   logic [15:0] tex_ff;
   logic [31:0] lx_ff, ly_ff, lz_ff;
   logic [15:0] w_ff, h_ff, px_ff, py_ff;
   logic [63:0] uv_ff;
   logic [31:0] colour_ff;

   // Result register
   logic [1:0]  kind_ff, kind_in;
   logic [31:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in, pos_z_ff, pos_z_in;
   logic [31:0] vcol_ff, vcol_in;
   logic [15:0] tex_u_ff, tex_u_in, tex_v_ff, tex_v_in;
   logic [4:0]  rslot_ff, rslot_in;
   logic [15:0] bound_ff, bound_in;
   logic [18:0] icount_ff, icount_in;
   logic        last_ff, last_in;

   // RAM ports
   logic           slot_we;
   logic [SAW-1:0] slot_wr_addr, slot_rd_addr;
   logic [15:0]    slot_rd_data, slot_entry;
   logic           col_we;
   logic [CAW-1:0] col_wr_addr, col_rd_addr;
   logic [31:0]    col_rd_data, col_top;

   logic           accept;
   logic           csr_write;
   logic [15:0]    quad_limit;
   logic [5:0]     eff_slot_limit;
   logic [3:0]     ret_state;
   logic           idx_is_last;
   logic [15:0]    dx, dz;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = !busy;
   assign csr_write = csr_valid && csr_ready;

   // max_quads of zero acts as one; slot_limit saturates to the usable range.
   assign quad_limit = (max_quads_ff == 16'd0) ? 16'd1 : max_quads_ff;
   always_comb begin
      if (slot_limit_ff < SLOT_LIMIT_FLOOR) begin
         eff_slot_limit = SLOT_LIMIT_FLOOR;
      end else if (slot_limit_ff > 6'(SLOT_DEPTH)) begin
         eff_slot_limit = 6'(SLOT_DEPTH);
      end else begin
         eff_slot_limit = slot_limit_ff;
      end
   end

   always_comb begin
      case (ret_ff)
         RET_SEARCH: ret_state = S_SR_PREP;
         RET_ADD:    ret_state = S_ADD;
         default:    ret_state = S_IDLE;
      endcase
   end

   // Slot 0 is never written: it always reads as the white texture.
   assign slot_entry  = slot_rd_zero_ff ? BLANK_TEXTURE : slot_rd_data;
   assign idx_is_last = ((UW'(idx_ff) + UW'(1)) == used_ff);

   // Bottom of the colour stack is never written: it reads as opaque white.
   assign col_rd_addr = CAW'(depth_ff - DW'(1));
   assign col_wr_addr = depth_ff[CAW-1:0];
   assign col_top     = (depth_ff == DW'(1)) ? WHITE_COLOUR : col_rd_data;

   // Corner offsets: only the upper half of the x and z positions moves; y is passed through.
   assign dx = (vc_ff[0] ? w_ff : 16'd0) - px_ff;
   assign dz = (vc_ff[1] ? h_ff : 16'd0) - py_ff;

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      active_in     = active_ff;
      used_in       = used_ff;
      pending_in    = pending_ff;
      depth_in      = depth_ff;
      idx_in        = idx_ff;
      slot_in       = slot_ff;
      vc_in         = vc_ff;
      max_quads_in  = max_quads_ff;
      slot_limit_in = slot_limit_ff;
      slot_we       = 1'b0;
      slot_wr_addr  = SAW'(used_ff);
      slot_rd_addr  = '0;
      col_we        = 1'b0;
      rsp_valid_in  = 1'b0;
      kind_in       = KIND_VERTEX;
      pos_x_in      = '0;
      pos_y_in      = '0;
      pos_z_in      = '0;
      vcol_in       = '0;
      tex_u_in      = '0;
      tex_v_in      = '0;
      rslot_in      = '0;
      bound_in      = '0;
      icount_in     = '0;
      last_in       = 1'b0;

      if (csr_write) begin
         case (csr_index)
            CSR_MAX_QUADS:  max_quads_in  = csr_wdata;
            CSR_SLOT_LIMIT: slot_limit_in = csr_wdata[5:0];
            default:        ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_IDLE;
            case (cmd_ff)
               CMD_BEGIN: begin
                  // drop any pending batch
                  active_in  = 1'b1;
                  pending_in = '0;
                  used_in    = UW'(1);
               end
               CMD_DRAW: begin
                  if (active_ff && (tex_ff != 16'd0)) begin
                     if (pending_ff >= quad_limit) begin
                        ret_in   = RET_SEARCH;
                        state_in = S_FL_PREP;
                     end else begin
                        state_in = S_SR_PREP;
                     end
                  end
               end
               CMD_END: begin
                  if (active_ff) begin
                     active_in = 1'b0;
                     ret_in    = RET_IDLE;
                     state_in  = S_FL_PREP;
                  end
               end
               CMD_PUSH: begin
                  if (depth_ff < DW'(COLOUR_STACK_DEPTH)) begin
                     col_we   = 1'b1;
                     depth_in = depth_ff + DW'(1);
                  end
               end
               CMD_POP: begin
                  if (depth_ff > DW'(1)) begin
                     depth_in = depth_ff - DW'(1);
                  end
               end
               default: ;
            endcase
         end
         S_FL_PREP: begin
            if (pending_ff == 16'd0) begin
               used_in  = UW'(1);
               state_in = ret_state;
            end else begin
               slot_rd_addr = '0;
               idx_in       = '0;
               state_in     = S_FL_BIND;
            end
         end
         S_FL_BIND: begin
            rsp_valid_in = 1'b1;
            kind_in      = KIND_BIND;
            rslot_in     = 5'(idx_ff);
            bound_in     = slot_entry;
            slot_rd_addr = idx_ff + SAW'(1);
            idx_in       = idx_ff + SAW'(1);
            if (idx_is_last) begin
               state_in = S_FL_DRAW;
            end
         end
         S_FL_DRAW: begin
            rsp_valid_in = 1'b1;
            kind_in      = KIND_DRAW;
            icount_in    = {1'b0, pending_ff, 2'b00} + {2'b00, pending_ff, 1'b0};
            last_in      = (ret_ff == RET_IDLE);
            pending_in   = '0;
            used_in      = UW'(1);
            state_in     = ret_state;
         end
         S_SR_PREP: begin
            slot_rd_addr = '0;
            idx_in       = '0;
            state_in     = S_SR;
         end
         S_SR: begin
            if (slot_entry == tex_ff) begin
               slot_in  = idx_ff;
               vc_in    = '0;
               state_in = S_VTX;
            end else if (idx_is_last) begin
               state_in = S_MISS;
            end else begin
               slot_rd_addr = idx_ff + SAW'(1);
               idx_in       = idx_ff + SAW'(1);
            end
         end
         S_MISS: begin
            if (6'(used_ff) >= eff_slot_limit) begin
               ret_in   = RET_ADD;
               state_in = S_FL_PREP;
            end else begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            slot_we  = 1'b1;
            slot_in  = SAW'(used_ff);
            used_in  = used_ff + UW'(1);
            vc_in    = '0;
            state_in = S_VTX;
         end
         S_VTX: begin
            // corners: top left, top right, bottom left, bottom right
            rsp_valid_in = 1'b1;
            kind_in      = KIND_VERTEX;
            pos_x_in     = {lx_ff[31:16] + dx, lx_ff[15:0]};
            pos_y_in     = ly_ff;
            pos_z_in     = {lz_ff[31:16] + dz, lz_ff[15:0]};
            vcol_in      = col_top;
            tex_u_in     = vc_ff[0] ? uv_ff[47:32] : uv_ff[15:0];
            tex_v_in     = vc_ff[1] ? uv_ff[63:48] : uv_ff[31:16];
            rslot_in     = 5'(slot_ff);
            vc_in        = vc_ff + 2'd1;
            if (&vc_ff) begin
               last_in    = 1'b1;
               pending_in = pending_ff + 16'd1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ret_ff        <= RET_IDLE;
         active_ff     <= 1'b0;
         used_ff       <= UW'(1);
         pending_ff    <= '0;
         depth_ff      <= DW'(1);
         idx_ff        <= '0;
         slot_ff       <= '0;
         vc_ff         <= '0;
         max_quads_ff  <= MAX_QUADS_RESET;
         slot_limit_ff <= SLOT_LIMIT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ret_ff        <= ret_in;
         active_ff     <= active_in;
         used_ff       <= used_in;
         pending_ff    <= pending_in;
         depth_ff      <= depth_in;
         idx_ff        <= idx_in;
         slot_ff       <= slot_in;
         vc_ff         <= vc_in;
         max_quads_ff  <= max_quads_in;
         slot_limit_ff <= slot_limit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload: hold the item, load results; no reset needed.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= req_cmd;
         tex_ff    <= req_texture_id;
         lx_ff     <= req_loc_x;
         ly_ff     <= req_loc_y;
         lz_ff     <= req_loc_z;
         w_ff      <= req_size_w;
         h_ff      <= req_size_h;
         px_ff     <= req_pivot_x;
         py_ff     <= req_pivot_y;
         uv_ff     <= req_uv_rect;
         colour_ff <= req_colour;
      end
      slot_rd_zero_ff <= (slot_rd_addr == '0);
      kind_ff   <= kind_in;
      pos_x_ff  <= pos_x_in;
      pos_y_ff  <= pos_y_in;
      pos_z_ff  <= pos_z_in;
      vcol_ff   <= vcol_in;
      tex_u_ff  <= tex_u_in;
      tex_v_ff  <= tex_v_in;
      rslot_ff  <= rslot_in;
      bound_ff  <= bound_in;
      icount_ff <= icount_in;
      last_ff   <= last_in;
   end

   sba_ram #(
      .WIDTH (16),
      .DEPTH (SLOT_DEPTH)
   ) u_slot_table (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_wr_addr),
      .wr_data (tex_ff),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd_data)
   );

   sba_ram #(
      .WIDTH (32),
      .DEPTH (COLOUR_STACK_DEPTH)
   ) u_colour_stack (
      .clock   (clock),
      .wr_en   (col_we),
      .wr_addr (col_wr_addr),
      .wr_data (colour_ff),
      .rd_addr (col_rd_addr),
      .rd_data (col_rd_data)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_pos_x         = pos_x_ff;
   assign rsp_pos_y         = pos_y_ff;
   assign rsp_pos_z         = pos_z_ff;
   assign rsp_vert_colour   = vcol_ff;
   assign rsp_tex_u         = tex_u_ff;
   assign rsp_tex_v         = tex_v_ff;
   assign rsp_slot          = rslot_ff;
   assign rsp_bound_texture = bound_ff;
   assign rsp_index_count   = icount_ff;
   assign rsp_last          = last_ff;

   // An accepted item always occupies the sequencer for the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted item did not raise busy");

   // Colour stack depth stays between one and its capacity.
   a_depth_range: assert property (@(posedge clock) disable iff (reset)
      (depth_ff >= DW'(1)) && (depth_ff <= DW'(COLOUR_STACK_DEPTH)))
      else $error("colour stack depth out of range");

   // A vertex always names a slot that is in use in the current batch.
   a_vertex_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_VERTEX)) |-> (6'(rsp_slot) < 6'(used_ff)))
      else $error("vertex slot beyond slots in use");

   // A draw record only goes out for a non-empty batch.
   a_draw_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_DRAW)) |-> (rsp_index_count != 19'd0))
      else $error("draw record with no quads");

endmodule
